// ===== sv/mcc_pkg.sv =====
`default_nettype none
package mcc_pkg;

   localparam int CACHE_SLOTS    = 64;
   localparam int ENTRIES_PER_TP = 512;
   localparam int SECTORS_PER_PAGE = 4;

   localparam int PAGE_W  = 24;
   localparam int AGE_W   = 32;
   localparam int COUNT_W = 25;
   localparam int ADDR_W  = 27;
   localparam int SLOT_W  = $clog2(CACHE_SLOTS);
   localparam int FILL_W  = $clog2(CACHE_SLOTS + 1);

   localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1048576);

   typedef enum logic [1:0] {
      CMD_TRANS_RD = 2'd0,
      CMD_TRANS_WR = 2'd1,
      CMD_DATA_RD  = 2'd2,
      CMD_DATA_WR  = 2'd3
   } cmd_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_VICTIM_RD,
      ST_VICTIM_WR,
      ST_TRANS_RD,
      ST_DATA
   } state_type;

   typedef struct packed {
      logic [PAGE_W-1:0] logical_page;
      logic              action;
   } req_type;

   typedef struct packed {
      cmd_kind_type      command_kind;
      logic [ADDR_W-1:0] sector_address;
      logic              lookup_hit;
      logic              last_command;
   } rsp_type;

   typedef struct packed {
      logic [PAGE_W-1:0] page;
      logic [AGE_W-1:0]  age;
   } slot_entry_type;

   function automatic logic [AGE_W-1:0] age_inc(input logic [AGE_W-1:0] a);
      return (a == AGE_MAX) ? AGE_MAX : a + AGE_W'(1);
   endfunction

   // first sector of the translation page holding page p
   function automatic logic [ADDR_W-1:0] trans_sector(input logic [PAGE_W-1:0] p);
      logic [PAGE_W-1:0] tp;
      logic [31:0]       prod;
      tp   = p / PAGE_W'(ENTRIES_PER_TP);
      prod = 32'(tp) * 32'(SECTORS_PER_PAGE);
      return prod[ADDR_W-1:0];
   endfunction

   // first sector of data page p, placed after the translation region
   function automatic logic [ADDR_W-1:0] data_sector(input logic [PAGE_W-1:0] p,
                                                     input logic [COUNT_W-1:0] cnt);
      logic [COUNT_W:0] rsum;
      logic [COUNT_W:0] region;
      logic [COUNT_W:0] psum;
      logic [31:0]      prod;
      rsum   = (COUNT_W+1)'(cnt) + (COUNT_W+1)'(ENTRIES_PER_TP - 1);
      region = rsum / (COUNT_W+1)'(ENTRIES_PER_TP);
      psum   = (COUNT_W+1)'(p) + region;
      prod   = 32'(psum) * 32'(SECTORS_PER_PAGE);
      return prod[ADDR_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== sv/mcc_slot_ram.sv =====
`default_nettype none
module mcc_slot_ram (
   input  wire logic                           clock,
   input  wire logic                           wr_en,
   input  wire logic [mcc_pkg::SLOT_W-1:0]     wr_addr,
   input  wire mcc_pkg::slot_entry_type        wr_data,
   input  wire logic                           rd_en,
   input  wire logic [mcc_pkg::SLOT_W-1:0]     rd_addr,
   output      mcc_pkg::slot_entry_type        rd_data
);
   import mcc_pkg::*;

   slot_entry_type mem [CACHE_SLOTS];
   slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== sv/mapping_cache_controller.sv =====
`default_nettype none
// Channel      Ports                               Handshake
// request      start, busy, req_item               taken when start && !busy
// response     rsp_valid, rsp_item                 one rsp_valid pulse per command, no backpressure
// config       csr_wr_en, csr_wr_data              written when csr_wr_en
//
// A transaction scans the filled slots through one registered RAM read port, one slot per
// cycle, then issues 1 to 4 commands; a full cache with a dirty victim issues all 4.
// Reset: synchronous; clears slot count, dirty bits and highest age, reloads the config reg.
// Slots fill in index order and are never freed (eviction overwrites a slot in place), so valid
// slots are always the range below the fill count; no clearing pass. The response side cannot stall.
module mapping_cache_controller (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output      logic                          busy,
   input  wire mcc_pkg::req_type              req_item,
   output      logic                          rsp_valid,
   output      mcc_pkg::rsp_type              rsp_item,
   input  wire logic                          csr_wr_en,
   input  wire logic [mcc_pkg::COUNT_W-1:0]   csr_wr_data
);
   import mcc_pkg::*;

   state_type state_ff, state_in;

   logic [COUNT_W-1:0]   map_count_ff;

   // latched transaction
   logic [PAGE_W-1:0]    page_ff;
   logic                 is_read_ff;

   // scan pipeline: issue index, then compare in the next cycle on RAM data
   logic [FILL_W-1:0]    issue_idx_ff;
   logic                 chk_vld_ff;
   logic [SLOT_W-1:0]    chk_idx_ff;

   // scan results
   logic                 hit_ff;
   logic [SLOT_W-1:0]    hit_idx_ff;
   logic [AGE_W-1:0]     hit_age_ff;
   logic                 vic_found_ff;
   logic [SLOT_W-1:0]    vic_idx_ff;
   logic [AGE_W-1:0]     vic_age_ff;
   logic [PAGE_W-1:0]    vic_page_ff;

   // cache bookkeeping
   logic [CACHE_SLOTS-1:0] dirty_ff;
   logic [AGE_W-1:0]     highest_age_ff;
   logic [FILL_W-1:0]    filled_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 accept;
   logic                 issue;
   logic                 scan_done;
   logic                 cache_full;
   slot_entry_type       rd_data;
   logic                 tag_match;
   logic                 take_victim;

   // commit of the transaction in the data-command cycle
   logic                 commit;
   logic [SLOT_W-1:0]    fill_slot;
   logic [AGE_W-1:0]     hit_new_age;
   logic [AGE_W-1:0]     miss_new_age;
   slot_entry_type       wr_entry;

   assign accept      = start && !busy;
   assign busy        = (state_ff != ST_IDLE);
   assign cache_full  = (filled_ff == FILL_W'(CACHE_SLOTS));
   assign issue       = (state_ff == ST_SCAN) && (issue_idx_ff < filled_ff);
   assign scan_done   = (issue_idx_ff == filled_ff) && !chk_vld_ff;
   assign tag_match   = chk_vld_ff && (rd_data.page == page_ff);
   // ties move the victim to the later (higher) slot
   assign take_victim = chk_vld_ff && (!vic_found_ff || (rd_data.age <= vic_age_ff));

   assign hit_new_age  = age_inc(hit_age_ff);
   assign miss_new_age = age_inc(highest_age_ff);
   assign fill_slot    = hit_ff ? hit_idx_ff :
                         (cache_full ? vic_idx_ff : filled_ff[SLOT_W-1:0]);
   assign wr_entry     = '{page: page_ff, age: (hit_ff ? hit_new_age : miss_new_age)};

   mcc_slot_ram u_slot_ram (
      .clock   (clock),
      .wr_en   (commit),
      .wr_addr (fill_slot),
      .wr_data (wr_entry),
      .rd_en   (issue),
      .rd_addr (issue_idx_ff[SLOT_W-1:0]),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               if (hit_ff) begin
                  state_in = ST_DATA;
               end else if (cache_full && dirty_ff[vic_idx_ff]) begin
                  state_in = ST_VICTIM_RD;
               end else begin
                  state_in = ST_TRANS_RD;
               end
            end
         end
         ST_VICTIM_RD: state_in = ST_VICTIM_WR;
         ST_VICTIM_WR: state_in = ST_TRANS_RD;
         ST_TRANS_RD:  state_in = ST_DATA;
         ST_DATA:      state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      rsp_valid_in = 1'b0;
      commit       = 1'b0;
      rsp_in       = '{command_kind: CMD_TRANS_RD,
                       sector_address: trans_sector(page_ff),
                       lookup_hit: hit_ff,
                       last_command: 1'b0};
      case (state_ff)
         ST_VICTIM_RD: begin
            rsp_valid_in          = 1'b1;
            rsp_in.sector_address = trans_sector(vic_page_ff);
         end
         ST_VICTIM_WR: begin
            rsp_valid_in          = 1'b1;
            rsp_in.command_kind   = CMD_TRANS_WR;
            rsp_in.sector_address = trans_sector(vic_page_ff);
         end
         ST_TRANS_RD: begin
            rsp_valid_in = 1'b1;
         end
         ST_DATA: begin
            rsp_valid_in          = 1'b1;
            commit                = 1'b1;
            rsp_in.command_kind   = is_read_ff ? CMD_DATA_RD : CMD_DATA_WR;
            rsp_in.sector_address = data_sector(page_ff, map_count_ff);
            rsp_in.last_command   = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         map_count_ff   <= COUNT_RESET;
         dirty_ff       <= '0;
         highest_age_ff <= '0;
         filled_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
         chk_vld_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         chk_vld_ff   <= issue;
         if (csr_wr_en) begin
            map_count_ff <= csr_wr_data;
         end
         if (commit) begin
            if (hit_ff) begin
               if (hit_new_age > highest_age_ff) begin
                  highest_age_ff <= hit_new_age;
               end
               if (!is_read_ff) begin
                  dirty_ff[fill_slot] <= 1'b1;
               end
            end else begin
               highest_age_ff      <= miss_new_age;
               dirty_ff[fill_slot] <= !is_read_ff;
               if (!cache_full) begin
                  filled_ff <= filled_ff + FILL_W'(1);
               end
            end
         end
      end
   end

   // transaction and scan datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         issue_idx_ff <= '0;
         hit_ff       <= 1'b0;
         vic_found_ff <= 1'b0;
      end else begin
         if (accept) begin
            issue_idx_ff <= '0;
            hit_ff       <= 1'b0;
            vic_found_ff <= 1'b0;
         end else begin
            if (issue) begin
               issue_idx_ff <= issue_idx_ff + FILL_W'(1);
            end
            if (tag_match && !hit_ff) begin
               hit_ff <= 1'b1;
            end
            if (take_victim) begin
               vic_found_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         page_ff    <= req_item.logical_page;
         is_read_ff <= req_item.action;
      end
      if (issue) begin
         chk_idx_ff <= issue_idx_ff[SLOT_W-1:0];
      end
      if (tag_match && !hit_ff) begin
         hit_idx_ff <= chk_idx_ff;
         hit_age_ff <= rd_data.age;
      end
      if (take_victim) begin
         vic_idx_ff  <= chk_idx_ff;
         vic_age_ff  <= rd_data.age;
         vic_page_ff <= rd_data.page;
      end
      if (rsp_valid_in) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // only the data command closes a transaction
   a_last_is_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.last_command ==
         ((rsp_item.command_kind == CMD_DATA_RD) || (rsp_item.command_kind == CMD_DATA_WR))))
      else $error("last_command does not match data command");

   // a hit never causes translation traffic
   a_hit_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.lookup_hit) |-> rsp_item.last_command)
      else $error("translation command on a hit");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      filled_ff <= FILL_W'(CACHE_SLOTS))
      else $error("fill count past cache size");

   // a dirty victim write-back only happens with a full cache
   a_victim_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_VICTIM_RD) |-> (cache_full && !hit_ff))
      else $error("eviction without a full cache");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after a transaction was taken");

endmodule
`default_nettype wire
